// File: src/qsm_pkg.sv
// ----------------------------------------------------------------------------
// qsm_pkg
// Shared types for the median-of-three quicksort block: channel items,
// controller states, store access pairs and controller/datapath bundles.
// ----------------------------------------------------------------------------
package qsm_pkg;

	localparam int VALUE_BITS = 32;

	typedef struct packed {
		logic [VALUE_BITS-1:0] element_value;
		logic                  is_last;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] sorted_value;
		logic                  is_final;
		logic                  dropped_elements;
	} out_item_t;

	typedef struct packed {
		logic descending_order;
	} cfg_item_t;

	// Which two store entries a read fetches; single reads fetch one entry on both ports.
	typedef enum logic [3:0] {
		PR_LO,
		PR_I,
		PR_J,
		PR_K,
		PR_LO_HI,
		PR_MID_HI,
		PR_MID_LO,
		PR_LO_MID,
		PR_I_J,
		PR_LO_J,
		PR_M1_M
	} pair_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_START,
		ST_LOOP,
		ST_MED_A,
		ST_MED_B,
		ST_MED_C,
		ST_MED_D,
		ST_PIV_RD,
		ST_PIV_LD,
		ST_SCAN_I,
		ST_SCAN_I_CMP,
		ST_SCAN_J,
		ST_SCAN_J_CMP,
		ST_PART,
		ST_PART_STEP,
		ST_PIV_PUT,
		ST_PUSH,
		ST_INS_INIT,
		ST_INS_K,
		ST_INS_M,
		ST_INS_RET,
		ST_BREAK,
		ST_POP,
		ST_OUT_INIT,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_CS_RD,
		ST_CS_CMP,
		ST_CS_WA,
		ST_CS_WB
	} state_t;

	typedef struct packed {
		logic  load_elem;
		logic  rd_en;
		pair_t pair;
		logic  wr_a;
		logic  wr_b;
		logic  start;
		logic  set_mid;
		logic  pv_load;
		logic  inc_i;
		logic  dec_j;
		logic  push_split;
		logic  pop;
		logic  ins_init;
		logic  set_m;
		logic  inc_k;
		logic  dec_m;
		logic  out_init;
		logic  out_load;
		logic  run_clear;
	} ctl_cmd_t;

	typedef struct packed {
		logic lo_lt_hi;
		logic span_lt2;
		logic span_eq2;
		logic i_lt_hi;
		logic j_gt_lo;
		logic i_lt_j;
		logic after_ab;
		logic after_pv_a;
		logic after_a_pv;
		logic stack_full;
		logic stack_empty;
		logic k_le_phi;
		logic m_gt_plo;
		logic k_lt_count;
		logic count_lt2;
		logic out_free;
	} ctl_sts_t;

endpackage

// File: src/qsm_stream_if.sv
// ----------------------------------------------------------------------------
// qsm_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface qsm_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/qsm_datapath.sv
// ----------------------------------------------------------------------------
// qsm_datapath
// Element store, range stack, index registers, comparator and output register.
// ----------------------------------------------------------------------------
module qsm_datapath
	import qsm_pkg::*;
#(
	parameter int STORE_DEPTH   = 64,
	parameter int ELEMENT_BITS  = 32,
	parameter int STACK_ENTRIES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output ctl_sts_t              sts,
	input  logic [VALUE_BITS-1:0] in_value,
	input  logic                  cfg_valid,
	input  logic                  cfg_desc,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item
);

	localparam int IW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW  = $clog2(STORE_DEPTH + 1);
	localparam int XW  = IW + 2;
	localparam int SIW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
	localparam int SPW = $clog2(STACK_ENTRIES + 1);

	typedef logic signed [XW-1:0] idx_t;
	localparam idx_t ONE = idx_t'(1);

	logic [ELEMENT_BITS-1:0] mem [STORE_DEPTH];
	idx_t                    stk_lo_q [STACK_ENTRIES];
	idx_t                    stk_hi_q [STACK_ENTRIES];

	logic [CW-1:0]           count_q;
	logic                    ovf_q;
	logic                    desc_q;
	logic [SPW-1:0]          sp_q;
	idx_t                    lo_q, hi_q, mid_q, i_q, j_q, k_q, m_q, plo_q, phi_q;
	idx_t                    ra_q, rb_q, ra_d, rb_d;
	logic [ELEMENT_BITS-1:0] rda_q, rdb_q, pv_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	idx_t                    cnt_x, span, new_plo, new_phi;
	logic [XW:0]             mid_sum;
	logic [SPW-1:0]          sp_m1;
	logic                    we;
	logic [IW-1:0]           wa;
	logic [ELEMENT_BITS-1:0] wd;

	// True when a belongs after b in the selected order.
	function automatic logic after(input logic [ELEMENT_BITS-1:0] a,
	                               input logic [ELEMENT_BITS-1:0] b,
	                               input logic desc);
		after = desc ? (a < b) : (a > b);
	endfunction

	assign cnt_x   = idx_t'(count_q);
	assign span    = hi_q - lo_q;
	assign mid_sum = {lo_q[XW-1], lo_q} + {hi_q[XW-1], hi_q};
	assign sp_m1   = sp_q - SPW'(1);

	always_comb begin
		if ((j_q - lo_q) > (hi_q - j_q)) begin
			new_plo = lo_q;
			new_phi = j_q - ONE;
		end else begin
			new_plo = j_q + ONE;
			new_phi = hi_q;
		end
	end

	always_comb begin
		case (cmd.pair)
			PR_LO:     begin ra_d = lo_q;       rb_d = lo_q; end
			PR_I:      begin ra_d = i_q;        rb_d = i_q;  end
			PR_J:      begin ra_d = j_q;        rb_d = j_q;  end
			PR_K:      begin ra_d = k_q;        rb_d = k_q;  end
			PR_LO_HI:  begin ra_d = lo_q;       rb_d = hi_q; end
			PR_MID_HI: begin ra_d = mid_q;      rb_d = hi_q; end
			PR_MID_LO: begin ra_d = mid_q;      rb_d = lo_q; end
			PR_LO_MID: begin ra_d = lo_q;       rb_d = mid_q; end
			PR_I_J:    begin ra_d = i_q;        rb_d = j_q;  end
			PR_LO_J:   begin ra_d = lo_q;       rb_d = j_q;  end
			PR_M1_M:   begin ra_d = m_q - ONE;  rb_d = m_q;  end
			default:   begin ra_d = lo_q;       rb_d = lo_q; end
		endcase
	end

	// Single write port shared by loading and the two halves of a swap.
	always_comb begin
		we = 1'b0;
		wa = ra_q[IW-1:0];
		wd = rdb_q;
		if (cmd.load_elem) begin
			we = (count_q < CW'(STORE_DEPTH));
			wa = count_q[IW-1:0];
			wd = ELEMENT_BITS'(in_value);
		end else if (cmd.wr_a) begin
			we = 1'b1;
		end else if (cmd.wr_b) begin
			we = 1'b1;
			wa = rb_q[IW-1:0];
			wd = rda_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_en) begin
			rda_q <= mem[ra_d[IW-1:0]];
			rdb_q <= mem[rb_d[IW-1:0]];
			ra_q  <= ra_d;
			rb_q  <= rb_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_q <= '0;
			hi_q <= cnt_x - ONE;
		end else if (cmd.push_split) begin
			plo_q <= new_plo;
			phi_q <= new_phi;
			if ((j_q - lo_q) > (hi_q - j_q)) begin
				lo_q <= j_q + ONE;
			end else begin
				hi_q <= j_q - ONE;
			end
		end else if (cmd.pop) begin
			lo_q <= stk_lo_q[sp_m1[SIW-1:0]];
			hi_q <= stk_hi_q[sp_m1[SIW-1:0]];
		end
		if (cmd.push_split && (sp_q != SPW'(STACK_ENTRIES))) begin
			stk_lo_q[sp_q[SIW-1:0]] <= new_plo;
			stk_hi_q[sp_q[SIW-1:0]] <= new_phi;
		end
		if (cmd.set_mid) begin
			mid_q <= idx_t'(mid_sum[XW:1]);
		end
		if (cmd.pv_load) begin
			pv_q <= rda_q;
			i_q  <= lo_q + ONE;
			j_q  <= hi_q;
		end else begin
			if (cmd.inc_i) begin
				i_q <= i_q + ONE;
			end
			if (cmd.dec_j) begin
				j_q <= j_q - ONE;
			end
		end
		if (cmd.ins_init) begin
			k_q <= plo_q + ONE;
		end else if (cmd.out_init) begin
			k_q <= '0;
		end else if (cmd.inc_k) begin
			k_q <= k_q + ONE;
		end
		if (cmd.set_m) begin
			m_q <= k_q;
		end else if (cmd.dec_m) begin
			m_q <= m_q - ONE;
		end
		if (cmd.out_load) begin
			out_q.sorted_value     <= VALUE_BITS'(rda_q);
			out_q.is_final         <= ((k_q + ONE) == cnt_x);
			out_q.dropped_elements <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			desc_q      <= 1'b0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				desc_q <= cfg_desc;
			end
			if (cmd.run_clear) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.load_elem) begin
				if (count_q < CW'(STORE_DEPTH)) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				sp_q <= '0;
			end else if (cmd.push_split && (sp_q != SPW'(STACK_ENTRIES))) begin
				sp_q <= sp_q + SPW'(1);
			end else if (cmd.pop) begin
				sp_q <= sp_m1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.lo_lt_hi    = (lo_q < hi_q);
		sts.span_lt2    = (span < idx_t'(2));
		sts.span_eq2    = (span == idx_t'(2));
		sts.i_lt_hi     = (i_q < hi_q);
		sts.j_gt_lo     = (j_q > lo_q);
		sts.i_lt_j      = (i_q < j_q);
		sts.after_ab    = after(rda_q, rdb_q, desc_q);
		sts.after_pv_a  = after(pv_q, rda_q, desc_q);
		sts.after_a_pv  = after(rda_q, pv_q, desc_q);
		sts.stack_full  = (sp_q == SPW'(STACK_ENTRIES));
		sts.stack_empty = (sp_q == '0);
		sts.k_le_phi    = (k_q <= phi_q);
		sts.m_gt_plo    = (m_q > plo_q);
		sts.k_lt_count  = (k_q < cnt_x);
		sts.count_lt2   = (count_q < CW'(2));
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: src/qsm_controller.sv
// ----------------------------------------------------------------------------
// qsm_controller
// Sequencer for loading, quicksort, insertion fallback and unloading.
// ----------------------------------------------------------------------------
module qsm_controller
	import qsm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_last,
	output logic     in_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	state_t state_q, state_d, ret_q, ret_d;
	pair_t  pair_q, pair_d;
	logic   always_q, always_d, swapped_q, swapped_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			ret_q     <= ST_LOAD;
			pair_q    <= PR_LO;
			always_q  <= 1'b0;
			swapped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ret_q     <= ret_d;
			pair_q    <= pair_d;
			always_q  <= always_d;
			swapped_q <= swapped_d;
		end
	end

	// Next state. A compare-and-swap is a small subroutine: the caller
	// records the pair, whether the swap is unconditional and where to return.
	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		pair_d    = pair_q;
		always_d  = always_q;
		swapped_d = swapped_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid && in_last) state_d = ST_START;
			end
			ST_START: state_d = sts.count_lt2 ? ST_OUT_INIT : ST_LOOP;
			ST_LOOP: begin
				if (!sts.lo_lt_hi) begin
					state_d = ST_BREAK;
				end else if (sts.span_lt2) begin
					state_d = ST_CS_RD; pair_d = PR_LO_HI; always_d = 1'b0; ret_d = ST_BREAK;
				end else begin
					state_d = ST_MED_A;
				end
			end
			ST_MED_A: begin
				state_d = ST_CS_RD; pair_d = PR_MID_HI; always_d = 1'b0; ret_d = ST_MED_B;
			end
			ST_MED_B: begin
				state_d = ST_CS_RD; pair_d = PR_MID_LO; always_d = 1'b0; ret_d = ST_MED_C;
			end
			ST_MED_C: begin
				if (swapped_q) begin
					state_d = ST_MED_D;
				end else begin
					state_d = ST_CS_RD; pair_d = PR_LO_HI; always_d = 1'b0; ret_d = ST_MED_D;
				end
			end
			ST_MED_D: begin
				if (sts.span_eq2) begin
					state_d = ST_CS_RD; pair_d = PR_LO_MID; always_d = 1'b1; ret_d = ST_BREAK;
				end else begin
					state_d = ST_PIV_RD;
				end
			end
			ST_PIV_RD:     state_d = ST_PIV_LD;
			ST_PIV_LD:     state_d = ST_SCAN_I;
			ST_SCAN_I:     state_d = sts.i_lt_hi ? ST_SCAN_I_CMP : ST_SCAN_J;
			ST_SCAN_I_CMP: state_d = sts.after_pv_a ? ST_SCAN_I : ST_SCAN_J;
			ST_SCAN_J:     state_d = sts.j_gt_lo ? ST_SCAN_J_CMP : ST_PART;
			ST_SCAN_J_CMP: state_d = sts.after_a_pv ? ST_SCAN_J : ST_PART;
			ST_PART: begin
				if (sts.i_lt_j) begin
					state_d = ST_CS_RD; pair_d = PR_I_J; always_d = 1'b1; ret_d = ST_PART_STEP;
				end else begin
					state_d = ST_PIV_PUT;
				end
			end
			ST_PART_STEP: state_d = ST_SCAN_I;
			ST_PIV_PUT: begin
				state_d = ST_CS_RD; pair_d = PR_LO_J; always_d = 1'b1; ret_d = ST_PUSH;
			end
			ST_PUSH:     state_d = sts.stack_full ? ST_INS_INIT : ST_LOOP;
			ST_INS_INIT: state_d = ST_INS_K;
			ST_INS_K:    state_d = sts.k_le_phi ? ST_INS_M : ST_LOOP;
			ST_INS_M: begin
				if (sts.m_gt_plo) begin
					state_d = ST_CS_RD; pair_d = PR_M1_M; always_d = 1'b0; ret_d = ST_INS_RET;
				end else begin
					state_d = ST_INS_K;
				end
			end
			ST_INS_RET:  state_d = swapped_q ? ST_INS_M : ST_INS_K;
			ST_BREAK:    state_d = sts.stack_empty ? ST_OUT_INIT : ST_POP;
			ST_POP:      state_d = ST_LOOP;
			ST_OUT_INIT: state_d = ST_OUT_RD;
			ST_OUT_RD: begin
				if (!sts.k_lt_count) begin
					state_d = ST_LOAD;
				end else if (sts.out_free) begin
					state_d = ST_OUT_LD;
				end
			end
			ST_OUT_LD: state_d = ST_OUT_RD;
			ST_CS_RD:  state_d = ST_CS_CMP;
			ST_CS_CMP: begin
				swapped_d = always_q || sts.after_ab;
				state_d   = (always_q || sts.after_ab) ? ST_CS_WA : ret_q;
			end
			ST_CS_WA: state_d = ST_CS_WB;
			ST_CS_WB: state_d = ret_q;
			default:  state_d = ST_LOAD;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd      = '0;
		cmd.pair = PR_LO;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready      = 1'b1;
				cmd.load_elem = in_valid;
			end
			ST_START:      cmd.start = 1'b1;
			ST_LOOP:       cmd.set_mid = 1'b1;
			ST_PIV_RD:     begin cmd.rd_en = 1'b1; cmd.pair = PR_LO; end
			ST_PIV_LD:     cmd.pv_load = 1'b1;
			ST_SCAN_I:     begin cmd.rd_en = 1'b1; cmd.pair = PR_I; end
			ST_SCAN_I_CMP: cmd.inc_i = sts.after_pv_a;
			ST_SCAN_J:     begin cmd.rd_en = 1'b1; cmd.pair = PR_J; end
			ST_SCAN_J_CMP: cmd.dec_j = sts.after_a_pv;
			ST_PART_STEP:  begin cmd.inc_i = 1'b1; cmd.dec_j = 1'b1; end
			ST_PUSH:       cmd.push_split = 1'b1;
			ST_INS_INIT:   cmd.ins_init = 1'b1;
			ST_INS_K:      cmd.set_m = 1'b1;
			ST_INS_M:      cmd.inc_k = !sts.m_gt_plo;
			ST_INS_RET: begin
				cmd.dec_m = swapped_q;
				cmd.inc_k = !swapped_q;
			end
			ST_POP:      cmd.pop = 1'b1;
			ST_OUT_INIT: cmd.out_init = 1'b1;
			ST_OUT_RD: begin
				cmd.rd_en     = 1'b1;
				cmd.pair      = PR_K;
				cmd.run_clear = !sts.k_lt_count;
			end
			ST_OUT_LD: begin
				cmd.out_load = 1'b1;
				cmd.inc_k    = 1'b1;
			end
			ST_CS_RD: begin
				cmd.rd_en = 1'b1;
				cmd.pair  = pair_q;
			end
			ST_CS_WA: cmd.wr_a = 1'b1;
			ST_CS_WB: cmd.wr_b = 1'b1;
			default: begin
				cmd.pair = PR_LO;
			end
		endcase
	end

endmodule

// File: src/quicksort_median_of_three.sv
// Loading accepts one element per cycle. After the item marked last, each
// compare-and-swap reads its pair and compares it, and when it swaps writes
// the two entries back one after the other on the single-write store.
// Unloading reads each item from the store and loads it into the output
// register, waiting while that register still holds an unaccepted result.
// Reset (arst_n low) clears the element count, overflow flag, stack pointer,
// order register and output valid at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// quicksort_median_of_three
// Buffers a run of elements, sorts it in place by non-recursive quicksort and
// streams the sorted run back out.
// ----------------------------------------------------------------------------
module quicksort_median_of_three
	import qsm_pkg::*;
#(
	parameter int STORE_DEPTH   = 64,
	parameter int ELEMENT_BITS  = 32,
	parameter int STACK_ENTRIES = 8
) (
	input logic         clk,
	input logic         arst_n,
	qsm_stream_if.sink   elements,
	qsm_stream_if.source sorted,
	qsm_stream_if.sink   order_cfg
);

	ctl_cmd_t  cmd;
	ctl_sts_t  sts;
	in_item_t  in_item;
	out_item_t out_item;
	cfg_item_t cfg_item;

	assign in_item  = elements.data;
	assign cfg_item = order_cfg.data;

	// The order register is a plain flop and can take a write every cycle.
	assign order_cfg.ready = 1'b1;

	// The controller walks the quicksort one store access at a time; the
	// datapath owns the store, the range stack and every index register.
	qsm_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (elements.valid),
		.in_last  (in_item.is_last),
		.in_ready (elements.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qsm_datapath #(
		.STORE_DEPTH   (STORE_DEPTH),
		.ELEMENT_BITS  (ELEMENT_BITS),
		.STACK_ENTRIES (STACK_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_value  (in_item.element_value),
		.cfg_valid (order_cfg.valid),
		.cfg_desc  (cfg_item.descending_order),
		.out_valid (sorted.valid),
		.out_ready (sorted.ready),
		.out_item  (out_item)
	);

	// The output register lets the final result wait while the next run loads.
	assign sorted.data = out_item;

endmodule

// File: src/qsm_checker.sv
// ----------------------------------------------------------------------------
// qsm_checker
// Port-level checks for the quicksort block, bound to the top level.
// ----------------------------------------------------------------------------
module qsm_checker
	import qsm_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  in_last,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] out_value,
	input logic                  out_final
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_final))
		else $error("stalled result changed");

	// The item marked last starts the sort, so no item is taken right after.
	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input taken right after last item");

	// Only the final result of a run may still wait while a new run loads.
	a_load_only_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_ready |-> out_final)
		else $error("loading while a run is still unloading");

endmodule

bind quicksort_median_of_three qsm_checker u_qsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (elements.valid),
	.in_ready  (elements.ready),
	.in_last   (elements.data.is_last),
	.out_valid (sorted.valid),
	.out_ready (sorted.ready),
	.out_value (sorted.data.sorted_value),
	.out_final (sorted.data.is_final)
);
